FILE: hw/rtl/pid_pkg.sv
package pid_pkg;

    // Fixed formats: data and gains are signed Q16.16, time step is unsigned Q0.16
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 16;
    localparam int LIMIT_W   = DATA_W - 1;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = DATA_W + 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SAT_MAG_W = PROD_W - FRAC_BITS;
    localparam int REM_W     = DT_W + 1;
    localparam int QCNT_W    = $clog2(DATA_W);

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(DATA_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(DATA_MIN);

    localparam logic [SAT_MAG_W-1:0] SAT_NEG_LIM = SAT_MAG_W'(1) << (DATA_W - 1);
    localparam logic [SAT_MAG_W-1:0] SAT_POS_LIM = SAT_NEG_LIM - SAT_MAG_W'(1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_MODE = 3'd4;

    // Derivative modes
    localparam logic [MODE_W-1:0] MODE_ERR_DIFF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEG_RATE = 2'd2;

    typedef struct packed {
        data_t            setpoint;
        data_t            measured;
        data_t            measured_rate;
        logic [DT_W-1:0]  time_step;
    } pid_in_t;

    typedef struct packed {
        data_t drive;
        logic  integral_clamped;
    } pid_out_t;

    // Shared multiplier request/response
    typedef struct packed {
        logic  valid;
        data_t op_a;
        data_t op_b;
    } pid_mul_req_t;

    typedef struct packed {
        logic  valid;
        data_t value;
    } pid_mul_rsp_t;

    // Serial divider request/response
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DATA_W:0]   mag;
        logic [DT_W-1:0]   dt;
    } pid_div_req_t;

    typedef struct packed {
        logic  busy;
        data_t value;
    } pid_div_rsp_t;

    // Apply a sign to a magnitude and saturate to the data range
    function automatic data_t signed_sat(input logic neg, input logic [SAT_MAG_W-1:0] m);
        data_t r;
        if (neg) begin
            r = (m > SAT_NEG_LIM) ? DATA_MIN : data_t'(-m[DATA_W-1:0]);
        end else begin
            r = (m > SAT_POS_LIM) ? DATA_MAX : data_t'(m[DATA_W-1:0]);
        end
        return r;
    endfunction

    // Saturate a widened signed sum back to the data range
    function automatic data_t sat_wide(input logic signed [ACC_W-1:0] v);
        data_t r;
        if (v > ACC_MAX) begin
            r = DATA_MAX;
        end else if (v < ACC_MIN) begin
            r = DATA_MIN;
        end else begin
            r = data_t'(v[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/pid_mul.sv
module pid_mul
    import pid_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  pid_mul_req_t req,
    output pid_mul_rsp_t rsp
);

    logic [DATA_W-1:0] a_mag_reg, b_mag_reg;
    logic              neg0_reg, neg1_reg;
    logic              v0_reg, v1_reg, v2_reg;
    logic [PROD_W-1:0] prod_reg;
    data_t             value_reg;
    logic [DATA_W-1:0] a_mag_next, b_mag_next;

    // Sign/magnitude split of the operands
    always_comb begin
        a_mag_next = req.op_a[DATA_W-1] ? DATA_W'(-req.op_a) : DATA_W'(req.op_a);
        b_mag_next = req.op_b[DATA_W-1] ? DATA_W'(-req.op_b) : DATA_W'(req.op_b);
    end

    // Valid pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= req.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Magnitudes, product, then shift and saturate
    always_ff @(posedge aclk) begin
        a_mag_reg <= a_mag_next;
        b_mag_reg <= b_mag_next;
        neg0_reg  <= req.op_a[DATA_W-1] ^ req.op_b[DATA_W-1];
        prod_reg  <= PROD_W'(a_mag_reg) * PROD_W'(b_mag_reg);
        neg1_reg  <= neg0_reg;
        value_reg <= signed_sat(neg1_reg, prod_reg[PROD_W-1:FRAC_BITS]);
    end

    assign rsp.valid = v2_reg;
    assign rsp.value = value_reg;

endmodule

FILE: hw/rtl/pid_div.sv
module pid_div
    import pid_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  pid_div_req_t req,
    output pid_div_rsp_t rsp
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_SAT  = 3'b100
    } div_state_t;

    div_state_t        state_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DATA_W-1:0] sh_reg;
    logic [DATA_W-1:0] q_reg;
    logic [DT_W-1:0]   dt_reg;
    logic              neg_reg;
    data_t             value_reg;

    logic [REM_W:0]    trial;
    logic              ge;
    logic [REM_W:0]    diff;
    logic              ovf;

    // One quotient bit per cycle, restoring
    always_comb begin
        trial = {rem_reg, sh_reg[DATA_W-1]};
        ge    = trial >= (REM_W+1)'(dt_reg);
        diff  = trial - (REM_W+1)'(dt_reg);
        // quotient would not fit in DATA_W bits
        ovf   = req.mag >= (DATA_W+1)'({req.dt, {DT_W{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            unique case (state_reg)
                D_IDLE: begin
                    if (req.start && req.dt != '0 && !ovf) begin
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (cnt_reg == '0) begin
                        state_reg <= D_SAT;
                    end
                end
                D_SAT: begin
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    if (req.dt == '0) begin
                        value_reg <= '0;
                    end else if (ovf) begin
                        value_reg <= req.neg ? DATA_MIN : DATA_MAX;
                    end
                end
                rem_reg <= req.mag[DATA_W:DT_W];
                sh_reg  <= {req.mag[DT_W-1:0], {(DATA_W-DT_W){1'b0}}};
                dt_reg  <= req.dt;
                neg_reg <= req.neg;
                cnt_reg <= QCNT_W'(DATA_W - 1);
                q_reg   <= '0;
            end
            D_RUN: begin
                rem_reg <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                q_reg   <= {q_reg[DATA_W-2:0], ge};
                sh_reg  <= {sh_reg[DATA_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
            D_SAT: begin
                value_reg <= signed_sat(neg_reg, SAT_MAG_W'(q_reg));
            end
            default: ;
        endcase
    end

    assign rsp.busy  = state_reg != D_IDLE;
    assign rsp.value = value_reg;

endmodule

FILE: hw/rtl/pid_controller_step.sv
// PID step with integral clamp, signed Q16.16. One transaction in gives one
// transaction out. A sequencer runs every product through one shared
// 32x32 multiplier (four products per item). In error-difference mode the
// 32-step serial divider is started alongside the first product and sets the
// pace. A zero time step, or a quotient beyond the data range, skips the
// divider. The input is accepted only while the sequencer is idle. A finished
// result waits in the output register, and a stalled output holds the
// sequencer in its last step. Configuration registers are written through
// cfg_wr_en / cfg_index / cfg_wr_data and should only change while no
// transaction is in flight.
module pid_controller_step
    import pid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pid_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pid_out_t             m_data
);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_ERR        = 8'b0000_0010,
        ST_INTEG      = 8'b0000_0100,
        ST_PROP       = 8'b0000_1000,
        ST_INT_TERM   = 8'b0001_0000,
        ST_DERIV      = 8'b0010_0000,
        ST_DERIV_TERM = 8'b0100_0000,
        ST_OUT        = 8'b1000_0000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Configuration
    data_t              gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [MODE_W-1:0]  mode_reg;

    // Controller state
    data_t integral_sum_reg, last_error_reg;

    // Item working registers
    data_t                   sp_reg, ms_reg, rate_reg, err_reg, d_reg;
    logic [DT_W-1:0]         dt_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    clamped_reg;
    logic                    issued_reg;

    logic     m_valid_reg;
    pid_out_t m_data_reg;

    pid_mul_req_t mul_req;
    pid_mul_rsp_t mul_rsp;
    pid_div_req_t div_req;
    pid_div_rsp_t div_rsp;

    logic                    s_fire, out_load;
    logic signed [DATA_W:0]  diff;
    logic signed [ACC_W-1:0] integ_sum;
    data_t                   integ_sat, limit_s, neg_limit, integ_new, neg_rate, d_sel;
    logic                    clamp_hi, clamp_lo;
    logic signed [ACC_W-1:0] acc_add;

    pid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    pid_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = state_reg == ST_IDLE;
    assign s_fire  = s_valid && s_ready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= '0;
            mode_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN_P:     gain_p_reg <= data_t'(cfg_wr_data);
                REG_GAIN_I:     gain_i_reg <= data_t'(cfg_wr_data);
                REG_GAIN_D:     gain_d_reg <= data_t'(cfg_wr_data);
                REG_INT_LIMIT:  limit_reg  <= cfg_wr_data[LIMIT_W-1:0];
                REG_DERIV_MODE: mode_reg   <= cfg_wr_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Integral update and clamp, error difference, derivative select, accumulator add
    always_comb begin
        diff      = (DATA_W+1)'(err_reg) - (DATA_W+1)'(last_error_reg);
        integ_sum = ACC_W'(integral_sum_reg) + ACC_W'(mul_rsp.value);
        integ_sat = sat_wide(integ_sum);
        limit_s   = data_t'({1'b0, limit_reg});
        neg_limit = -limit_s;
        clamp_hi  = (limit_reg != '0) && (integ_sat > limit_s);
        clamp_lo  = (limit_reg != '0) && (integ_sat < neg_limit);
        integ_new = clamp_hi ? limit_s : (clamp_lo ? neg_limit : integ_sat);
        neg_rate  = (rate_reg == DATA_MIN) ? DATA_MAX : -rate_reg;
        if (mode_reg == MODE_ERR_DIFF) begin
            d_sel = div_rsp.value;
        end else if (mode_reg == MODE_NEG_RATE) begin
            d_sel = neg_rate;
        end else begin
            d_sel = '0;
        end
        acc_add = acc_reg + ACC_W'(mul_rsp.value);
    end

    // Multiplier and divider requests
    always_comb begin
        mul_req.valid = 1'b0;
        mul_req.op_a  = err_reg;
        mul_req.op_b  = data_t'(dt_reg);
        case (state_reg)
            ST_INTEG: begin
                mul_req.valid = !issued_reg;
            end
            ST_PROP: begin
                mul_req.valid = !issued_reg;
                mul_req.op_b  = gain_p_reg;
            end
            ST_INT_TERM: begin
                mul_req.valid = !issued_reg;
                mul_req.op_a  = integral_sum_reg;
                mul_req.op_b  = gain_i_reg;
            end
            ST_DERIV_TERM: begin
                mul_req.valid = !issued_reg;
                mul_req.op_a  = d_reg;
                mul_req.op_b  = gain_d_reg;
            end
            default: ;
        endcase
        div_req.start = (state_reg == ST_INTEG) && !issued_reg && (mode_reg == MODE_ERR_DIFF);
        div_req.neg   = diff[DATA_W];
        div_req.mag   = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
        div_req.dt    = dt_reg;
    end

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_fire) state_next = ST_ERR;
            ST_ERR:        state_next = ST_INTEG;
            ST_INTEG:      if (mul_rsp.valid) state_next = ST_PROP;
            ST_PROP:       if (mul_rsp.valid) state_next = ST_INT_TERM;
            ST_INT_TERM:   if (mul_rsp.valid) state_next = ST_DERIV;
            ST_DERIV:      if (!div_rsp.busy) state_next = ST_DERIV_TERM;
            ST_DERIV_TERM: if (mul_rsp.valid) state_next = ST_OUT;
            ST_OUT:        if (out_load) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            issued_reg       <= 1'b0;
            integral_sum_reg <= '0;
            last_error_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_rsp.valid) begin
                issued_reg <= 1'b0;
            end else if (mul_req.valid) begin
                issued_reg <= 1'b1;
            end
            if (state_reg == ST_INTEG && !issued_reg) begin
                last_error_reg <= err_reg;
            end
            if (state_reg == ST_INTEG && mul_rsp.valid) begin
                integral_sum_reg <= integ_new;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sp_reg   <= s_data.setpoint;
            ms_reg   <= s_data.measured;
            rate_reg <= s_data.measured_rate;
            dt_reg   <= s_data.time_step;
        end
        if (state_reg == ST_ERR) begin
            err_reg <= sat_wide(ACC_W'(sp_reg) - ACC_W'(ms_reg));
        end
        if (state_reg == ST_INTEG && mul_rsp.valid) begin
            clamped_reg <= clamp_hi || clamp_lo;
        end
        if (state_reg == ST_PROP && mul_rsp.valid) begin
            acc_reg <= ACC_W'(mul_rsp.value);
        end
        if ((state_reg == ST_INT_TERM || state_reg == ST_DERIV_TERM) && mul_rsp.valid) begin
            acc_reg <= acc_add;
        end
        if (state_reg == ST_DERIV) begin
            d_reg <= d_sel;
        end
        if (out_load) begin
            m_data_reg.drive            <= sat_wide(acc_reg);
            m_data_reg.integral_clamped <= clamped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/pid_checker.sv
module pid_checker
    import pid_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input pid_out_t m_data
);

    // The sequencer takes one transaction at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a step is in progress");

    // A result never appears in the cycle right after an input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result produced too early");

    // A new result is only loaded from the busy sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the sequencer was idle");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

endmodule

bind pid_controller_step pid_checker u_pid_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
